// ===== hdl/sbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sbe_pkg;

    // store sizes; the field widths of the words fix them
    localparam int PROGRAM_BYTES = 1024;
    localparam int HANDLER_SLOTS = 16;
    localparam int LOCAL_SLOTS   = 16;
    localparam int STACK_DEPTH   = 32;

    typedef struct packed {
        logic [2:0]  mode;
        logic [9:0]  address;
        logic [31:0] data;
        logic [9:0]  handler_start;
        logic [10:0] handler_end;
        logic        handler_verified;
        logic [15:0] cycle_budget;
    } sbe_in_t;

    typedef struct packed {
        logic [31:0] accumulator;
        logic [10:0] program_counter;
        logic [5:0]  stack_fill;
        logic [15:0] current_handler;
        logic [15:0] next_handler;
        logic        ready_res;
        logic [2:0]  stop_reason;
        logic [31:0] read_value;
    } sbe_out_t;

    localparam logic [2:0] MODE_LOAD_PROG  = 3'd0;
    localparam logic [2:0] MODE_LOAD_HNDL  = 3'd1;
    localparam logic [2:0] MODE_WRITE_LOC  = 3'd2;
    localparam logic [2:0] MODE_READ_LOC   = 3'd3;
    localparam logic [2:0] MODE_EXECUTE    = 3'd4;

    localparam logic [2:0] STOP_BUDGET   = 3'd0;
    localparam logic [2:0] STOP_RETURN   = 3'd1;
    localparam logic [2:0] STOP_UNVERIF  = 3'd2;
    localparam logic [2:0] STOP_UNKNOWN  = 3'd3;
    localparam logic [2:0] STOP_HOST     = 3'd4;

    localparam logic [7:0] OP_IMM8  = 8'd0;
    localparam logic [7:0] OP_IMM16 = 8'd1;
    localparam logic [7:0] OP_IMM24 = 8'd2;
    localparam logic [7:0] OP_IMM32 = 8'd3;
    localparam logic [7:0] OP_PSH   = 8'd4;
    localparam logic [7:0] OP_POP   = 8'd5;
    localparam logic [7:0] OP_BZ    = 8'd6;
    localparam logic [7:0] OP_BNZ   = 8'd7;
    localparam logic [7:0] OP_LDLOC = 8'd8;
    localparam logic [7:0] OP_STLOC = 8'd9;
    localparam logic [7:0] OP_SETST = 8'd10;
    localparam logic [7:0] OP_OR    = 8'd11;
    localparam logic [7:0] OP_XOR   = 8'd12;
    localparam logic [7:0] OP_AND   = 8'd13;
    localparam logic [7:0] OP_EQ    = 8'd14;
    localparam logic [7:0] OP_NE    = 8'd15;
    localparam logic [7:0] OP_LTU   = 8'd16;
    localparam logic [7:0] OP_LTS   = 8'd17;
    localparam logic [7:0] OP_GTU   = 8'd18;
    localparam logic [7:0] OP_GTS   = 8'd19;
    localparam logic [7:0] OP_LEU   = 8'd20;
    localparam logic [7:0] OP_LES   = 8'd21;
    localparam logic [7:0] OP_GEU   = 8'd22;
    localparam logic [7:0] OP_GES   = 8'd23;
    localparam logic [7:0] OP_SHL   = 8'd24;
    localparam logic [7:0] OP_SHRU  = 8'd25;
    localparam logic [7:0] OP_SHRS  = 8'd26;
    localparam logic [7:0] OP_ADD   = 8'd27;
    localparam logic [7:0] OP_SUB   = 8'd28;
    localparam logic [7:0] OP_MUL   = 8'd29;
    localparam logic [7:0] OP_SYSC  = 8'd30;
    localparam logic [7:0] OP_RET   = 8'd31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_HREAD,
        ST_CHECK,
        ST_FETCH,
        ST_DECODE,
        ST_IMM,
        ST_POPWAIT,
        ST_ALU,
        ST_LOCRD,
        ST_DONE
    } sbe_state_t;

    function automatic logic [31:0] sbe_alu(input logic [7:0] op, input logic [31:0] s,
                                            input logic [31:0] a);
        logic [31:0] r;
        logic        lts;
        logic        gts;
        lts = $signed(s) < $signed(a);
        gts = $signed(a) < $signed(s);
        case (op)
            OP_OR:   r = s | a;
            OP_XOR:  r = s ^ a;
            OP_AND:  r = s & a;
            OP_EQ:   r = {31'd0, s == a};
            OP_NE:   r = {31'd0, s != a};
            OP_LTU:  r = {31'd0, s < a};
            OP_LTS:  r = {31'd0, lts};
            OP_GTU:  r = {31'd0, s > a};
            OP_GTS:  r = {31'd0, gts};
            OP_LEU:  r = {31'd0, s <= a};
            OP_LES:  r = {31'd0, !gts};
            OP_GEU:  r = {31'd0, s >= a};
            OP_GES:  r = {31'd0, !lts};
            OP_SHL:  r = s << a[4:0];
            OP_SHRU: r = s >> a[4:0];
            OP_SHRS: r = 32'($signed(s) >>> a[4:0]);
            OP_ADD:  r = s + a;
            OP_SUB:  r = s - a;
            default: r = s * a;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/stack_bytecode_executor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// host words: one word at a time, result registered via the done state, next word
// accepted the cycle after the result is taken
// execute: start, handler read (new handler), check, decode; then per instruction
// fetch, decode, one operand state per operand byte (immediate, branch offset, local
// index) or a pop state for pop and binary ops; result follows via the done state
// reset (aresetn low, synchronous) clears control, acc, pc, fill, flags and locals
module stack_bytecode_executor (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  sbe_pkg::sbe_in_t    s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output sbe_pkg::sbe_out_t   m_data
);
    import sbe_pkg::*;

    localparam int PW = (PROGRAM_BYTES > 1) ? $clog2(PROGRAM_BYTES) : 1;
    localparam int HW = (HANDLER_SLOTS > 1) ? $clog2(HANDLER_SLOTS) : 1;
    localparam int LW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]  prog_mem [PROGRAM_BYTES];
    logic [9:0]  hstart_mem [HANDLER_SLOTS];
    logic [10:0] hend_mem [HANDLER_SLOTS];
    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] loc_reg [LOCAL_SLOTS];
    logic [HANDLER_SLOTS-1:0] hok_reg;

    sbe_state_t  state_reg, state_next;
    logic [31:0] acc_reg, acc_next;
    logic [10:0] pc_reg, pc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0] run_reg, run_next;
    logic [15:0] chosen_reg, chosen_next;
    logic        rdy_reg, rdy_next;
    logic [15:0] budget_reg, budget_next;
    logic [10:0] end_reg, end_next;
    logic [7:0]  op_reg, op_next;
    logic [1:0]  immn_reg, immn_next;
    logic [1:0]  immk_reg, immk_next;
    logic [31:0] imm_reg, imm_next;
    logic [2:0]  reason_reg, reason_next;
    logic [31:0] readv_reg, readv_next;
    logic        mval_reg;

    logic [7:0]  prog_rd;
    logic [9:0]  hstart_rd;
    logic [10:0] hend_rd;
    logic [31:0] stack_rd;
    logic [PW-1:0] prog_raddr;
    logic [SW-1:0] stack_raddr;
    logic        stack_we;
    logic [31:0] stack_wdata;
    logic        loc_we;
    logic [LW-1:0] loc_waddr;
    logic [31:0] loc_wdata;
    logic [HW-1:0] slot;
    logic        accept;
    logic        pop_ok;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mval_reg;
    // a starting handler is looked up by its number before run_reg takes it
    assign slot = (state_reg == ST_START && rdy_reg) ? chosen_reg[HW-1:0] : run_reg[HW-1:0];
    assign pop_ok = (cnt_reg != '0);

    // program address: current pc
    assign prog_raddr = pc_reg[PW-1:0];
    assign stack_raddr = SW'(cnt_reg - CW'(1));

    always_ff @(posedge aclk) begin
        if (accept && s_data.mode == MODE_LOAD_PROG) begin
            prog_mem[s_data.address[PW-1:0]] <= s_data.data[7:0];
        end
        prog_rd <= prog_mem[prog_raddr];
    end

    always_ff @(posedge aclk) begin
        if (accept && s_data.mode == MODE_LOAD_HNDL) begin
            hstart_mem[s_data.address[HW-1:0]] <= s_data.handler_start;
            hend_mem[s_data.address[HW-1:0]] <= s_data.handler_end;
        end
        hstart_rd <= hstart_mem[slot];
        hend_rd <= hend_mem[slot];
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[cnt_reg[SW-1:0]] <= stack_wdata;
        end
        stack_rd <= stack_mem[stack_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hok_reg <= '0;
            for (int i = 0; i < LOCAL_SLOTS; i++) begin
                loc_reg[i] <= '0;
            end
        end else begin
            if (accept && s_data.mode == MODE_LOAD_HNDL) begin
                hok_reg[s_data.address[HW-1:0]] <= s_data.handler_verified;
            end
            if (accept && s_data.mode == MODE_WRITE_LOC) begin
                loc_reg[s_data.address[LW-1:0]] <= s_data.data;
            end else if (loc_we) begin
                loc_reg[loc_waddr] <= loc_wdata;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_data.mode == MODE_EXECUTE) ? ST_START : ST_DONE;
                end
            end
            ST_START:   state_next = rdy_reg ? ST_HREAD : ST_CHECK;
            ST_HREAD:   state_next = ST_CHECK;
            ST_CHECK: begin
                if (!hok_reg[slot] || budget_reg == '0 || pc_reg >= hend_rd) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DECODE;
                end
            end
            ST_FETCH: begin
                if (budget_reg == '0 || pc_reg >= end_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (prog_rd inside {[OP_IMM8:OP_IMM32], OP_BZ, OP_BNZ, OP_LDLOC,
                                    OP_STLOC, OP_SETST}) begin
                    state_next = ST_IMM;
                end else if (prog_rd inside {OP_POP, [OP_OR:OP_MUL]}) begin
                    state_next = ST_POPWAIT;
                end else if (prog_rd inside {OP_RET} || prog_rd > OP_RET) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_IMM: begin
                if (immk_reg == immn_reg) begin
                    state_next = ST_FETCH;
                end
            end
            ST_POPWAIT: state_next = ST_FETCH;
            ST_ALU:     state_next = ST_FETCH;
            ST_LOCRD:   state_next = ST_FETCH;
            ST_DONE: begin
                if (m_ready || !mval_reg) begin
                    state_next = mval_reg ? ST_IDLE : ST_DONE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        acc_next = acc_reg;
        pc_next = pc_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        chosen_next = chosen_reg;
        rdy_next = rdy_reg;
        budget_next = budget_reg;
        end_next = end_reg;
        op_next = op_reg;
        immn_next = immn_reg;
        immk_next = immk_reg;
        imm_next = imm_reg;
        reason_next = reason_reg;
        readv_next = readv_reg;
        stack_we = 1'b0;
        stack_wdata = acc_reg;
        loc_we = 1'b0;
        loc_waddr = '0;
        loc_wdata = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    reason_next = STOP_HOST;
                    readv_next = '0;
                    budget_next = s_data.cycle_budget;
                    if (s_data.mode == MODE_READ_LOC) begin
                        readv_next = loc_reg[s_data.address[LW-1:0]];
                    end
                end
            end
            ST_START: begin
                if (rdy_reg) begin
                    rdy_next = 1'b0;
                    run_next = chosen_reg;
                    cnt_next = '0;
                    acc_next = '0;
                end
            end
            ST_HREAD: begin
                pc_next = {1'b0, hstart_rd};
            end
            ST_CHECK: begin
                end_next = hend_rd;
                if (!hok_reg[slot]) begin
                    reason_next = STOP_UNVERIF;
                end else if (budget_reg == '0) begin
                    reason_next = STOP_BUDGET;
                end else if (pc_reg >= hend_rd) begin
                    reason_next = STOP_RETURN;
                    rdy_next = 1'b1;
                end else begin
                    budget_next = budget_reg - 16'd1;
                    pc_next = pc_reg + 11'd1;
                end
            end
            ST_FETCH: begin
                if (budget_reg == '0) begin
                    reason_next = STOP_BUDGET;
                end else if (pc_reg >= end_reg) begin
                    reason_next = STOP_RETURN;
                    rdy_next = 1'b1;
                end else begin
                    budget_next = budget_reg - 16'd1;
                    pc_next = pc_reg + 11'd1;
                end
            end
            ST_DECODE: begin
                op_next = prog_rd;
                immk_next = '0;
                imm_next = '0;
                case (prog_rd)
                    OP_IMM8:  immn_next = 2'd0;
                    OP_IMM16: immn_next = 2'd1;
                    OP_IMM24: immn_next = 2'd2;
                    OP_IMM32: immn_next = 2'd3;
                    OP_SETST: immn_next = 2'd1;
                    default:  immn_next = 2'd0;
                endcase
                if (prog_rd inside {[OP_IMM8:OP_IMM32], OP_LDLOC, OP_STLOC, OP_SETST}) begin
                    pc_next = pc_reg + 11'd1;
                end else if (prog_rd == OP_PSH) begin
                    if (cnt_reg < CW'(STACK_DEPTH)) begin
                        stack_we = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end else if (prog_rd == OP_RET) begin
                    reason_next = STOP_RETURN;
                    rdy_next = 1'b1;
                end else if (prog_rd > OP_RET) begin
                    reason_next = STOP_UNKNOWN;
                end
            end
            ST_IMM: begin
                // prog_rd holds the byte at pc-1 (at pc for a branch offset)
                imm_next = imm_reg | ({24'd0, prog_rd} << {immk_reg, 3'd0});
                immk_next = immk_reg + 2'd1;
                if (op_reg inside {OP_BZ, OP_BNZ}) begin
                    if ((op_reg == OP_BZ) == (acc_reg == '0)) begin
                        pc_next = pc_reg + 11'(prog_rd) + 11'd1;
                    end else begin
                        pc_next = pc_reg + 11'd1;
                    end
                end else if (immk_reg != immn_reg) begin
                    pc_next = pc_reg + 11'd1;
                end
                if (immk_reg == immn_reg) begin
                    case (op_reg)
                        OP_LDLOC: acc_next = loc_reg[prog_rd[LW-1:0]];
                        OP_STLOC: begin
                            loc_we = 1'b1;
                            loc_waddr = prog_rd[LW-1:0];
                        end
                        OP_SETST: chosen_next = imm_next[15:0];
                        OP_BZ, OP_BNZ: acc_next = acc_reg;
                        default:  acc_next = imm_next;
                    endcase
                end
            end
            ST_POPWAIT: begin
                if (pop_ok) begin
                    cnt_next = cnt_reg - CW'(1);
                end
                if (op_reg == OP_POP) begin
                    acc_next = pop_ok ? stack_rd : '0;
                end else begin
                    acc_next = sbe_alu(op_reg, pop_ok ? stack_rd : '0, acc_reg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg <= '0;
            pc_reg <= '0;
            cnt_reg <= '0;
            run_reg <= '0;
            chosen_reg <= '0;
            rdy_reg <= 1'b1;
            mval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg <= acc_next;
            pc_reg <= pc_next;
            cnt_reg <= cnt_next;
            run_reg <= run_next;
            chosen_reg <= chosen_next;
            rdy_reg <= rdy_next;
            if (state_reg == ST_DONE && !mval_reg) begin
                mval_reg <= 1'b1;
            end else if (mval_reg && m_ready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        budget_reg <= budget_next;
        end_reg <= end_next;
        op_reg <= op_next;
        immn_reg <= immn_next;
        immk_reg <= immk_next;
        imm_reg <= imm_next;
        reason_reg <= reason_next;
        readv_reg <= readv_next;
    end

    always_comb begin
        m_data.accumulator = acc_reg;
        m_data.program_counter = pc_reg;
        m_data.stack_fill = 6'(cnt_reg);
        m_data.current_handler = run_reg;
        m_data.next_handler = chosen_reg;
        m_data.ready_res = rdy_reg;
        m_data.stop_reason = reason_reg;
        m_data.read_value = readv_reg;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("word accepted while busy");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack fill beyond depth");
    a_result_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result outside done");
    a_unverif_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.stop_reason == STOP_UNVERIF) |-> !m_data.ready_res)
        else $error("unverified stop left ready set");
`endif

endmodule
`default_nettype wire
